@@ rtl/scfc_pkg.sv @@
// ----------------------------------------------------------------------------
// scfc_pkg
// Request codes, status codes, slot record type and the CRC-8 byte update
// shared by the sensor frame collector modules.
// ----------------------------------------------------------------------------
package scfc_pkg;

  // Request kinds
  localparam logic [1:0] KIND_POLL = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Report kinds
  localparam logic RPT_FRAME = 1'b0;
  localparam logic RPT_READ  = 1'b1;

  // Status codes, frame reports
  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_CRC_BAD = 2'd1;
  localparam logic [1:0] ST_ID_BAD  = 2'd2;
  // Status codes, read reports
  localparam logic [1:0] ST_REPLIED  = 2'd0;
  localparam logic [1:0] ST_NO_REPLY = 2'd1;

  // Frame layout: six bytes, the last one carries only CRC
  localparam int unsigned FrameBytes = 6;
  localparam logic [2:0]  LastPos    = 3'(FrameBytes - 1);

  localparam logic [7:0] CrcPoly = 8'h07;
  localparam logic [7:0] CrcInit = 8'hFF;

  typedef struct packed {
    logic [5:0]  addr;
    logic [8:0]  temp;
    logic [9:0]  hum;
    logic [12:0] co2;
  } slot_data_t;

  // Frame completion info from the assembler
  typedef struct packed {
    logic       done;
    logic       crc_ok;
    logic       frc;
    logic       asc;
    slot_data_t data;
  } frame_rpt_t;

  // CRC-8, MSB first, no reflection
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ rtl/scfc_frame_asm.sv @@
// ----------------------------------------------------------------------------
// scfc_frame_asm
// Byte assembler with running CRC-8; unpacks the frame on the last byte.
// ----------------------------------------------------------------------------
module scfc_frame_asm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 restart_i,
  input  logic                 byte_en_i,
  input  logic [7:0]           rx_byte_i,
  output scfc_pkg::frame_rpt_t rpt_o
);
  import scfc_pkg::*;

  logic [2:0]  pos_q, pos_d;
  logic [7:0]  crc_q, crc_d, crc_next;
  logic [39:0] bytes_q, bytes_d;
  logic        last;

  assign crc_next = crc8_byte(crc_q, rx_byte_i);
  assign last     = byte_en_i && (pos_q == LastPos);

  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    bytes_d = bytes_q;
    if (restart_i || last) begin
      pos_d   = '0;
      crc_d   = CrcInit;
      bytes_d = '0;
    end else if (byte_en_i) begin
      crc_d = crc_next;
      bytes_d[{pos_q, 3'b000} +: 8] = rx_byte_i;
      pos_d = pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= CrcInit;
      bytes_q <= '0;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      bytes_q <= bytes_d;
    end
  end

  // Unpack little-endian: temperature, humidity, CO2, then the flags and sensor address
  assign rpt_o.done      = last;
  assign rpt_o.crc_ok    = (crc_next == 8'h00);
  assign rpt_o.frc       = bytes_q[32];
  assign rpt_o.asc       = bytes_q[33];
  assign rpt_o.data.addr = bytes_q[39:34];
  assign rpt_o.data.temp = bytes_q[8:0];
  assign rpt_o.data.hum  = bytes_q[18:9];
  assign rpt_o.data.co2  = bytes_q[31:19];

endmodule

@@ rtl/scfc_slot_mem.sv @@
// ----------------------------------------------------------------------------
// scfc_slot_mem
// Slot table: synchronous memory with registered read, plus per-slot
// replied bits that reset clears. A slot without its bit reads with rd_replied_o low.
// ----------------------------------------------------------------------------
module scfc_slot_mem #(
  parameter int unsigned NUM_SLOTS = 32,
  parameter int unsigned IDX_W     = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clr_en_i,
  input  logic [IDX_W-1:0]     clr_idx_i,
  input  logic                 wr_en_i,
  input  logic [IDX_W-1:0]     wr_idx_i,
  input  scfc_pkg::slot_data_t wr_data_i,
  input  logic                 rd_en_i,
  input  logic [IDX_W-1:0]     rd_idx_i,
  output logic                 rd_replied_o,
  output scfc_pkg::slot_data_t rd_data_o
);
  import scfc_pkg::*;

  slot_data_t           mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] replied_q;
  logic                 rd_replied_q;
  slot_data_t           rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replied_q    <= '0;
      rd_replied_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        replied_q[wr_idx_i] <= 1'b1;
      end
      if (clr_en_i) begin
        replied_q[clr_idx_i] <= 1'b0;
      end
      if (rd_en_i) begin
        rd_replied_q <= replied_q[rd_idx_i];
      end
    end
  end

  assign rd_replied_o = rd_replied_q;
  assign rd_data_o    = rd_data_q;

endmodule

@@ rtl/sensor_frame_collector_crc8.sv @@
// ----------------------------------------------------------------------------
// sensor_frame_collector_crc8
// Results: a result strobes in the cycle after the request that causes it.
// Throughput: one request per cycle; busy stays low, nothing in the block
//   iterates and the slot memory port serves one access per cycle.
// Reset: frame assembly restarts, every slot reads as no reply.
// Results cannot be stalled: each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module sensor_frame_collector_crc8 #(
  parameter int unsigned NUM_SLOTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [4:0]  slot_i,
  input  logic [7:0]  rx_byte_i,
  output logic        result_valid_o,
  output logic        report_kind_o,
  output logic [1:0]  status_o,
  output logic [5:0]  sensor_address_o,
  output logic [8:0]  temperature_tenths_o,
  output logic [9:0]  humidity_tenths_o,
  output logic [12:0] co2_ppm_o,
  output logic        forced_recal_flag_o,
  output logic        auto_cal_flag_o
);
  import scfc_pkg::*;

  localparam int unsigned IdxW      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [6:0]  NumSlots7 = 7'(NUM_SLOTS);

  // Request decode
  logic       accept;
  logic       poll_en, byte_en, rd_req;
  logic [6:0] slot_ext;
  logic       slot_ok;

  // Every request completes its table access in the accept cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    poll_en = 1'b0;
    byte_en = 1'b0;
    rd_req  = 1'b0;
    if (accept) begin
      unique case (kind_i)
        KIND_POLL: poll_en = 1'b1;
        KIND_BYTE: byte_en = 1'b1;
        KIND_READ: rd_req  = 1'b1;
        default:   ;  // unused code: drop the request
      endcase
    end
  end

  assign slot_ext = {2'b00, slot_i};
  assign slot_ok  = slot_ext < NumSlots7;

  // Frame assembly and CRC check
  frame_rpt_t rpt;

  scfc_frame_asm u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (poll_en),
    .byte_en_i (byte_en),
    .rx_byte_i (rx_byte_i),
    .rpt_o     (rpt)
  );

  // A good frame lands in slot id-1; ids zero or beyond the table are refused
  logic       id_ok;
  logic [6:0] id_m1;
  logic       wr_en;

  assign id_ok = (rpt.data.addr != 6'd0) && ({1'b0, rpt.data.addr} <= NumSlots7);
  assign id_m1 = {1'b0, rpt.data.addr} - 7'd1;
  assign wr_en = rpt.done && rpt.crc_ok && id_ok;

  logic       mem_replied;
  slot_data_t mem_data;

  scfc_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IdxW)
  ) u_slots (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clr_en_i     (poll_en && slot_ok),
    .clr_idx_i    (slot_ext[IdxW-1:0]),
    .wr_en_i      (wr_en),
    .wr_idx_i     (id_m1[IdxW-1:0]),
    .wr_data_i    (rpt.data),
    .rd_en_i      (rd_req && slot_ok),
    .rd_idx_i     (slot_ext[IdxW-1:0]),
    .rd_replied_o (mem_replied),
    .rd_data_o    (mem_data)
  );

  // Result stage: frame reports are registered here, read data comes from
  // the memory's own read register in the cycle after the request.
  logic       res_valid_q, res_valid_d;
  logic       res_read_q, res_read_d;
  logic       rd_hit_q;
  logic [1:0] fr_status_q, fr_status_d;
  slot_data_t fr_data_q, fr_data_d;
  logic       fr_frc_q, fr_frc_d;
  logic       fr_asc_q, fr_asc_d;

  always_comb begin
    res_valid_d = rpt.done || rd_req;
    res_read_d  = rd_req;
    fr_status_d = ST_STORED;
    fr_data_d   = rpt.data;
    fr_frc_d    = rpt.frc;
    fr_asc_d    = rpt.asc;
    if (!rpt.crc_ok) begin
      // bad CRC: report nothing of the frame
      fr_status_d = ST_CRC_BAD;
      fr_data_d   = '0;
      fr_frc_d    = 1'b0;
      fr_asc_d    = 1'b0;
    end else if (!id_ok) begin
      fr_status_d = ST_ID_BAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_read_q  <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      res_read_q  <= res_read_d;
    end
  end

  // Payload holds; no reset needed
  always_ff @(posedge clk_i) begin
    if (rd_req) begin
      rd_hit_q <= slot_ok;
    end
    if (rpt.done) begin
      fr_status_q <= fr_status_d;
      fr_data_q   <= fr_data_d;
      fr_frc_q    <= fr_frc_d;
      fr_asc_q    <= fr_asc_d;
    end
  end

  // Output select: a slot out of range or never answered reads as no reply
  logic       rd_good;
  slot_data_t out_data;

  assign rd_good = rd_hit_q && mem_replied;

  always_comb begin
    if (res_read_q) begin
      status_o            = rd_good ? ST_REPLIED : ST_NO_REPLY;
      out_data            = rd_good ? mem_data : '0;
      forced_recal_flag_o = 1'b0;
      auto_cal_flag_o     = 1'b0;
    end else begin
      status_o            = fr_status_q;
      out_data            = fr_data_q;
      forced_recal_flag_o = fr_frc_q;
      auto_cal_flag_o     = fr_asc_q;
    end
  end

  assign result_valid_o       = res_valid_q;
  assign report_kind_o        = res_read_q ? RPT_READ : RPT_FRAME;
  assign sensor_address_o     = out_data.addr;
  assign temperature_tenths_o = out_data.temp;
  assign humidity_tenths_o    = out_data.hum;
  assign co2_ppm_o            = out_data.co2;

`ifndef NO_ASSERTIONS
  // A result only follows an accepted request
  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy))
    else $error("result without request");

  // Every read request gets its report in the next cycle
  a_read_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == KIND_READ) |=> (result_valid_o && report_kind_o))
    else $error("read request not answered");

  // A stored frame always carries a nonzero sensor address
  a_stored_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && report_kind_o == RPT_FRAME && status_o == ST_STORED)
      |-> (sensor_address_o != 6'd0))
    else $error("stored frame with address zero");

  // A poll never produces a result
  a_poll_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == KIND_POLL) |=> !result_valid_o)
    else $error("poll produced a result");
`endif

endmodule
